[hw/rtl/vsfc_pkg.sv]
package vsfc_pkg;

    // Default geometry of the store
    localparam int SIDE_DEF      = 16;
    localparam int HEIGHT_DEF    = 256;
    localparam int TYPE_BITS_DEF = 8;

    // Command codes
    localparam logic [2:0] CMD_PUT    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_FACE   = 3'd3;
    localparam logic [2:0] CMD_COLUMN = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_CHUNK_COL   = 2'd0;
    localparam logic [1:0] REG_CHUNK_ROW   = 2'd1;
    localparam logic [1:0] REG_SEE_THROUGH = 2'd2;

    localparam logic [7:0] SEE_THROUGH_RST = 8'd1;

    // Face directions
    localparam logic [2:0] FACE_LEFT   = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_TOP    = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_FRONT  = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;

    // Read steps of a face query: the cell itself, then its six neighbors
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_LEFT   = 3'd1;
    localparam logic [2:0] STEP_RIGHT  = 3'd2;
    localparam logic [2:0] STEP_TOP    = 3'd3;
    localparam logic [2:0] STEP_BOTTOM = 3'd4;
    localparam logic [2:0] STEP_FRONT  = 3'd5;
    localparam logic [2:0] STEP_BACK   = 3'd6;
    localparam logic [2:0] STEP_END    = 3'd7;

endpackage

[hw/rtl/voxel_store_face_culler.sv]
// Voxel store with face culling.
// Holds a SIDE x SIDE x HEIGHT store of block types in one single-port memory.
// Input channel (in_valid/in_ready) takes one request: put, remove, get, face
// query or column height. Output channel (out_valid/out_ready) returns the
// results of that request, the final one flagged by last; a face query returns
// one result per exposed face, or a single result without a face.
// Config channel (cfg_valid/cfg_ready, always ready) writes chunk_col (0),
// chunk_row (1) and the see-through type (2); write it only while idle.
// Put and remove write the cell when it lies in the store; a get waits for its
// memory read; a face query checks the cell and, when it is solid, its six
// neighbors, then sends one exposed face per cycle while the output is free; column
// height reads heights from the bottom up to the first empty one. The next
// request can be accepted in the cycle after the sequencer loads the last result.
// The output register lets the next request in while a result waits; a
// stalled receiver holds the sequencer before it loads another result.
// After reset the memory is cleared one cell per cycle, all SIDE*SIDE*HEIGHT
// cells (65536 by default); in_ready stays low during that pass, config
// writes are taken.
module voxel_store_face_culler
    import vsfc_pkg::*;
#(
    parameter int SIDE      = SIDE_DEF,
    parameter int HEIGHT    = HEIGHT_DEF,
    parameter int TYPE_BITS = TYPE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic [3:0]         pos_x,
    input  logic [7:0]         pos_y,
    input  logic [3:0]         pos_z,
    input  logic [7:0]         new_type,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_type,
    output logic [8:0]         column_top,
    output logic               has_face,
    output logic [2:0]         face_dir,
    output logic signed [15:0] world_x,
    output logic [7:0]         world_y,
    output logic signed [15:0] world_z,
    output logic [7:0]         face_type,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data
);

    localparam int CELLS  = SIDE * SIDE * HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int YW     = ($clog2(HEIGHT + 1) > 9) ? $clog2(HEIGHT + 1) : 9;
    localparam int CMP_W  = (TYPE_BITS > 8) ? TYPE_BITS : 8;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_GETW   = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_GATHER = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0]    ax,
                                                    input logic [YW-1:0] ay,
                                                    input logic [4:0]    az);
        return ADDR_W'(ay) * ADDR_W'(SIDE * SIDE) + ADDR_W'(ax) * ADDR_W'(SIDE)
            + ADDR_W'(az);
    endfunction

    function automatic logic is_solid(input logic [TYPE_BITS-1:0] t,
                                      input logic [7:0]           st);
        return (t != '0) && (CMP_W'(t) != CMP_W'(st));
    endfunction

    // Sequencer and item registers
    logic [2:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [2:0]           cmd_reg;
    logic [3:0]           x_reg;
    logic [7:0]           y_reg;
    logic [3:0]           z_reg;
    logic [TYPE_BITS-1:0] nt_reg;
    logic [TYPE_BITS-1:0] ctype_reg, ctype_next;
    logic [5:0]           mask_reg, mask_next;
    logic [2:0]           step_reg, step_next;
    logic                 pend_reg, pend_next;
    logic [2:0]           pend_tag_reg, pend_tag_next;
    logic                 pend_in_reg, pend_in_next;
    logic [YW-1:0]        walk_y_reg, walk_y_next;
    logic [YW-1:0]        pend_y_reg, pend_y_next;
    logic [7:0]           res_rt_reg, res_rt_next;
    logic [8:0]           res_ct_reg, res_ct_next;

    // Configuration
    logic signed [11:0]   chunk_col_reg;
    logic signed [11:0]   chunk_row_reg;
    logic [7:0]           see_through_reg;

    // Memory port
    logic [TYPE_BITS-1:0] mem [CELLS];
    logic [TYPE_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [TYPE_BITS-1:0] mem_wdata;

    // Output register
    logic                 out_valid_reg;
    logic [7:0]           read_type_reg, ld_read_type;
    logic [8:0]           column_top_reg, ld_column_top;
    logic                 has_face_reg, ld_has_face;
    logic [2:0]           face_dir_reg, ld_face_dir;
    logic signed [15:0]   world_x_reg, ld_world_x;
    logic [7:0]           world_y_reg, ld_world_y;
    logic signed [15:0]   world_z_reg, ld_world_z;
    logic [7:0]           face_type_reg, ld_face_type;
    logic                 last_reg, ld_last;
    logic                 out_load;
    logic                 out_free;

    // Access coordinates
    logic                 center_in;
    logic                 column_in;
    logic [4:0]           xe;
    logic [YW-1:0]        ye;
    logic [4:0]           ze;
    logic [4:0]           nb_x, acc_x;
    logic [YW-1:0]        nb_y, acc_y;
    logic [4:0]           nb_z, acc_z;
    logic                 nb_in;
    logic [2:0]           emit_dir;
    logic [5:0]           mask_clr;
    logic signed [15:0]   wx_off;
    logic signed [15:0]   wz_off;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    assign xe = {1'b0, x_reg};
    assign ye = YW'(y_reg);
    assign ze = {1'b0, z_reg};

    assign column_in = (int'(x_reg) < SIDE) && (int'(z_reg) < SIDE);
    assign center_in = column_in && (int'(y_reg) < HEIGHT);

    assign wx_off = 16'(chunk_col_reg * SIDE);
    assign wz_off = 16'(chunk_row_reg * SIDE);

    // Neighbor of the current face query step; an out-of-chunk one reads the cell itself
    always_comb
    begin
        nb_x  = xe;
        nb_y  = ye;
        nb_z  = ze;
        nb_in = 1'b1;
        unique case (step_reg)
            STEP_LEFT:
            begin
                nb_in = (x_reg != '0);
                if (nb_in) nb_x = xe - 5'd1;
            end
            STEP_RIGHT:
            begin
                nb_in = (int'(x_reg) + 1 < SIDE);
                if (nb_in) nb_x = xe + 5'd1;
            end
            STEP_TOP:
            begin
                nb_in = (int'(y_reg) + 1 < HEIGHT);
                if (nb_in) nb_y = ye + YW'(1);
            end
            STEP_BOTTOM:
            begin
                nb_in = (y_reg != '0);
                if (nb_in) nb_y = ye - YW'(1);
            end
            STEP_FRONT:
            begin
                nb_in = (int'(z_reg) + 1 < SIDE);
                if (nb_in) nb_z = ze + 5'd1;
            end
            STEP_BACK:
            begin
                nb_in = (z_reg != '0);
                if (nb_in) nb_z = ze - 5'd1;
            end
            default:
            begin
                nb_in = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        acc_x = xe;
        acc_y = ye;
        acc_z = ze;
        if (state_reg == S_WALK)
        begin
            acc_y = walk_y_reg;
        end
        else if (state_reg == S_GATHER)
        begin
            acc_x = nb_x;
            acc_y = nb_y;
            acc_z = nb_z;
        end
    end

    // Lowest exposed face goes out first
    always_comb
    begin
        emit_dir = FACE_LEFT;
        for (int d = 5; d >= 0; d--)
        begin
            if (mask_reg[d]) emit_dir = 3'(d);
        end
        mask_clr = mask_reg & ~(6'b1 << emit_dir);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        ctype_next    = ctype_reg;
        mask_next     = mask_reg;
        step_next     = step_reg;
        pend_next     = pend_reg;
        pend_tag_next = pend_tag_reg;
        pend_in_next  = pend_in_reg;
        walk_y_next   = walk_y_reg;
        pend_y_next   = pend_y_reg;
        res_rt_next   = res_rt_reg;
        res_ct_next   = res_ct_reg;

        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_addr  = cell_addr(acc_x, acc_y, acc_z);

        out_load      = 1'b0;
        ld_read_type  = '0;
        ld_column_top = '0;
        ld_has_face   = 1'b0;
        ld_face_dir   = FACE_LEFT;
        ld_world_x    = '0;
        ld_world_y    = '0;
        ld_world_z    = '0;
        ld_face_type  = '0;
        ld_last       = 1'b1;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(CELLS - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_rt_next = '0;
                res_ct_next = '0;
                mask_next   = '0;
                pend_next   = 1'b0;
                step_next   = STEP_CENTER;
                walk_y_next = '0;
                unique case (cmd_reg) inside
                    CMD_PUT, CMD_REMOVE:
                    begin
                        mem_we     = center_in;
                        mem_wdata  = (cmd_reg == CMD_PUT) ? nt_reg : '0;
                        state_next = S_FIN;
                    end
                    CMD_GET:
                    begin
                        state_next = S_GETW;
                    end
                    CMD_COLUMN:
                    begin
                        state_next = column_in ? S_WALK : S_FIN;
                    end
                    CMD_FACE:
                    begin
                        state_next = center_in ? S_GATHER : S_FIN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_GETW:
            begin
                res_rt_next = center_in ? 8'(rd_data_reg) : '0;
                state_next  = S_FIN;
            end
            S_WALK:
            begin
                // Read one height per cycle, check the one read the cycle before
                if (pend_reg && rd_data_reg == '0)
                begin
                    res_ct_next = (pend_y_reg > YW'(1)) ? 9'(pend_y_reg - YW'(1)) : '0;
                    pend_next   = 1'b0;
                    state_next  = S_FIN;
                end
                else if (walk_y_reg < YW'(HEIGHT))
                begin
                    pend_next   = 1'b1;
                    pend_y_next = walk_y_reg;
                    walk_y_next = walk_y_reg + YW'(1);
                end
                else
                begin
                    res_ct_next = 9'(HEIGHT);
                    pend_next   = 1'b0;
                    state_next  = S_FIN;
                end
            end
            S_GATHER:
            begin
                if (pend_reg)
                begin
                    if (pend_tag_reg == STEP_CENTER)
                    begin
                        ctype_next = rd_data_reg;
                        if (!is_solid(rd_data_reg, see_through_reg)) state_next = S_FIN;
                    end
                    else
                    begin
                        mask_next[3'(pend_tag_reg - STEP_LEFT)] =
                            !(pend_in_reg && is_solid(rd_data_reg, see_through_reg));
                        if (pend_tag_reg == STEP_BACK)
                            state_next = (mask_next == '0) ? S_FIN : S_EMIT;
                    end
                end
                if (step_reg != STEP_END)
                begin
                    pend_next     = 1'b1;
                    pend_tag_next = step_reg;
                    pend_in_next  = nb_in;
                    step_next     = step_reg + 3'd1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    ld_has_face  = 1'b1;
                    ld_face_dir  = emit_dir;
                    ld_world_x   = 16'(wx_off + 16'(x_reg));
                    ld_world_y   = y_reg;
                    ld_world_z   = 16'(wz_off + 16'(z_reg));
                    ld_face_type = 8'(ctype_reg);
                    ld_last      = (mask_clr == '0);
                    mask_next    = mask_clr;
                    if (mask_clr == '0) state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    ld_read_type  = res_rt_reg;
                    ld_column_top = res_ct_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            step_reg     <= STEP_CENTER;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            x_reg   <= pos_x;
            y_reg   <= pos_y;
            z_reg   <= pos_z;
            nt_reg  <= TYPE_BITS'(new_type);
        end
        ctype_reg    <= ctype_next;
        mask_reg     <= mask_next;
        pend_tag_reg <= pend_tag_next;
        pend_in_reg  <= pend_in_next;
        walk_y_reg   <= walk_y_next;
        pend_y_reg   <= pend_y_next;
        res_rt_reg   <= res_rt_next;
        res_ct_reg   <= res_ct_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_col_reg   <= '0;
            chunk_row_reg   <= '0;
            see_through_reg <= SEE_THROUGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHUNK_COL:   chunk_col_reg   <= cfg_data;
                REG_CHUNK_ROW:   chunk_row_reg   <= cfg_data;
                REG_SEE_THROUGH: see_through_reg <= cfg_data[7:0];
                default:         see_through_reg <= see_through_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_type_reg  <= ld_read_type;
            column_top_reg <= ld_column_top;
            has_face_reg   <= ld_has_face;
            face_dir_reg   <= ld_face_dir;
            world_x_reg    <= ld_world_x;
            world_y_reg    <= ld_world_y;
            world_z_reg    <= ld_world_z;
            face_type_reg  <= ld_face_type;
            last_reg       <= ld_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_type  = read_type_reg;
    assign column_top = column_top_reg;
    assign has_face   = has_face_reg;
    assign face_dir   = face_dir_reg;
    assign world_x    = world_x_reg;
    assign world_y    = world_y_reg;
    assign world_z    = world_z_reg;
    assign face_type  = face_type_reg;
    assign last       = last_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not start execution");

    a_emit_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (mask_reg != '0))
        else $error("face emission with no exposed face left");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_EXEC))
        else $error("memory write outside clear or execute");

    a_gather_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER && pend_reg) |-> (pend_tag_reg + STEP_LEFT == step_reg))
        else $error("face query read tag out of step");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import vsfc_pkg::*;

    // Command codes the block does not know
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    // Register index with no register behind it
    localparam logic [1:0] REG_SPARE  = 2'd3;

    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int COLUMN_FILL = 16;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] x;
        logic [7:0] y;
        logic [3:0] z;
        logic [7:0] kind;
    } voxel_req_t;

    typedef struct packed {
        logic [7:0]  read_type;
        logic [8:0]  column_top;
        logic        has_face;
        logic [2:0]  face_dir;
        logic [15:0] world_x;
        logic [7:0]  world_y;
        logic [15:0] world_z;
        logic [7:0]  face_type;
        logic        last;
    } voxel_result_t;

    typedef enum int {FLOW, RANDOM_STALL, SLOW_DRAIN} ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  cmd = CMD_GET;
    logic [3:0]  pos_x = '0;
    logic [7:0]  pos_y = '0;
    logic [3:0]  pos_z = '0;
    logic [7:0]  new_type = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_type;
    logic [8:0]  column_top;
    logic        has_face;
    logic [2:0]  face_dir;
    logic signed [15:0] world_x;
    logic [7:0]  world_y;
    logic signed [15:0] world_z;
    logic [7:0]  face_type;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_CHUNK_COL;
    logic [11:0] cfg_data = '0;

    // Predictor state: the store and the register copies
    logic [7:0]  voxels [SIDE_DEF * SIDE_DEF * HEIGHT_DEF];
    logic [11:0] col_offset = '0;
    logic [11:0] row_offset = '0;
    logic [7:0]  see_through = SEE_THROUGH_RST;

    voxel_req_t    pending_requests [$];
    voxel_result_t expected_results [$];

    int          step_dx [6] = '{-1, 1, 0, 0, 0, 0};
    int          step_dy [6] = '{0, 0, 1, -1, 0, 0};
    int          step_dz [6] = '{0, 0, 0, 0, 1, -1};
    logic [2:0]  face_order [6] = '{FACE_LEFT, FACE_RIGHT, FACE_TOP, FACE_BOTTOM,
                                    FACE_FRONT, FACE_BACK};

    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned faces_checked;
    int unsigned reg_writes;
    int unsigned mismatches;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    int unsigned cycle_count;
    bit          hold_request;
    bit          hold_done;
    ready_mode_t ready_mode;

    voxel_store_face_culler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .new_type   (new_type),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_type  (read_type),
        .column_top (column_top),
        .has_face   (has_face),
        .face_dir   (face_dir),
        .world_x    (world_x),
        .world_y    (world_y),
        .world_z    (world_z),
        .face_type  (face_type),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int voxel_addr(int x, int y, int z);
        return (y * SIDE_DEF + x) * SIDE_DEF + z;
    endfunction

    // Cells outside the chunk read as empty
    function automatic logic [7:0] cell_at(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= SIDE_DEF || y >= HEIGHT_DEF || z >= SIDE_DEF)
            return '0;
        return voxels[voxel_addr(x, y, z)];
    endfunction

    function automatic bit is_solid(logic [7:0] kind);
        return kind != '0 && kind != see_through;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                     $time, results_checked, what, got, want);
    endtask

    task automatic check_result(voxel_result_t got, voxel_result_t want);
        if (got.read_type !== want.read_type)
            report_mismatch("read_type", got.read_type, want.read_type);
        if (got.column_top !== want.column_top)
            report_mismatch("column_top", got.column_top, want.column_top);
        if (got.has_face !== want.has_face)
            report_mismatch("has_face", got.has_face, want.has_face);
        if (got.face_dir !== want.face_dir)
            report_mismatch("face_dir", got.face_dir, want.face_dir);
        if (got.world_x !== want.world_x)
            report_mismatch("world_x", got.world_x, want.world_x);
        if (got.world_y !== want.world_y)
            report_mismatch("world_y", got.world_y, want.world_y);
        if (got.world_z !== want.world_z)
            report_mismatch("world_z", got.world_z, want.world_z);
        if (got.face_type !== want.face_type)
            report_mismatch("face_type", got.face_type, want.face_type);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    // Work out the results of the request now on the input ports
    task automatic predict_request();
        voxel_result_t plain;
        voxel_result_t face;
        logic [7:0]    kind;
        logic [5:0]    open_faces;
        logic [15:0]   wx;
        logic [15:0]   wz;
        int            total;
        int            sent;
        int            yy;
        bit            found;
        bit            faces_out;
        plain = '0;
        plain.last = 1'b1;
        faces_out = 1'b0;
        requests_sent++;
        case (cmd)
            CMD_PUT:    voxels[voxel_addr(pos_x, pos_y, pos_z)] = new_type;
            CMD_REMOVE: voxels[voxel_addr(pos_x, pos_y, pos_z)] = '0;
            CMD_GET:    plain.read_type = cell_at(pos_x, pos_y, pos_z);
            CMD_COLUMN:
            begin
                plain.column_top = 9'(HEIGHT_DEF);
                found = 1'b0;
                for (yy = 0; yy < HEIGHT_DEF && !found; yy++)
                begin
                    if (cell_at(pos_x, yy, pos_z) == '0)
                    begin
                        plain.column_top = (yy > 1) ? 9'(yy - 1) : '0;
                        found = 1'b1;
                    end
                end
            end
            CMD_FACE:
            begin
                kind = cell_at(pos_x, pos_y, pos_z);
                open_faces = '0;
                if (is_solid(kind))
                    for (int d = 0; d < 6; d++)
                        open_faces[d] = !is_solid(cell_at(int'(pos_x) + step_dx[d],
                                                          int'(pos_y) + step_dy[d],
                                                          int'(pos_z) + step_dz[d]));
                total = $countones(open_faces);
                wx = {{4{col_offset[11]}}, col_offset} * 16'd16 + {12'd0, pos_x};
                wz = {{4{row_offset[11]}}, row_offset} * 16'd16 + {12'd0, pos_z};
                sent = 0;
                for (int d = 0; d < 6; d++)
                begin
                    if (open_faces[d])
                    begin
                        sent++;
                        face = '0;
                        face.has_face = 1'b1;
                        face.face_dir = face_order[d];
                        face.world_x = wx;
                        face.world_y = pos_y;
                        face.world_z = wz;
                        face.face_type = kind;
                        face.last = (sent == total);
                        expected_results.insert(expected_results.size(), face);
                    end
                end
                faces_out = (total > 0);
            end
            default: ;
        endcase
        if (!faces_out)
            expected_results.insert(expected_results.size(), plain);
    endtask

    // Sender: bursts of requests with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            voxel_req_t next_req;
            if (in_valid && in_ready)
                predict_request();
            if (in_valid && !in_ready)
            begin
                // hold the request until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                cmd      <= next_req.cmd;
                pos_x    <= next_req.x;
                pos_y    <= next_req.y;
                pos_z    <= next_req.z;
                new_type <= next_req.kind;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: check each result, stall on a changing pattern, one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
            cycle_count = 0;
            ready_mode = FLOW;
        end
        else
        begin
            voxel_result_t got;
            if (out_valid && out_ready)
            begin
                got = {read_type, column_top, has_face, face_dir, world_x, world_y,
                       world_z, face_type, last};
                results_checked++;
                if (has_face === 1'b1)
                    faces_checked++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing pending, last", last, 0);
                else
                    check_result(got, expected_results.pop_front());
            end
            cycle_count++;
            if (cycle_count % 64 == 0)
                ready_mode = ready_mode_t'($urandom_range(0, 2));
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    FLOW:         out_ready <= 1'b1;
                    RANDOM_STALL: out_ready <= ($urandom_range(0, 99) >= 35);
                    default:      out_ready <= (cycle_count % 3 == 0);
                endcase
            end
        end
    end

    task automatic write_register(logic [1:0] index, logic [11:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (index)
            REG_CHUNK_COL:   col_offset = data;
            REG_CHUNK_ROW:   row_offset = data;
            REG_SEE_THROUGH: see_through = data[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic queue_request(logic [2:0] op, logic [3:0] x, logic [7:0] y,
                                 logic [3:0] z, logic [7:0] kind);
        pending_requests.insert(pending_requests.size(), voxel_req_t'({op, x, y, z, kind}));
    endtask

    // Mostly requests clustered around a moving anchor so cells get neighbors
    task automatic queue_random_run(int count);
        voxel_req_t r;
        int         ax;
        int         ay;
        int         az;
        int         pick;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            if (i % 10 == 0)
            begin
                pick = $urandom_range(0, 3);
                ax = (pick == 0) ? 0 : (pick == 1) ? 13 : $urandom_range(0, 13);
                pick = $urandom_range(0, 3);
                ay = (pick < 2) ? 0 : (pick == 2) ? 253 : $urandom_range(0, 253);
                pick = $urandom_range(0, 3);
                az = (pick == 0) ? 0 : (pick == 1) ? 13 : $urandom_range(0, 13);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                r.cmd = CMD_PUT;
            else if (pick < 50)
                r.cmd = CMD_REMOVE;
            else if (pick < 60)
                r.cmd = CMD_GET;
            else if (pick < 85)
                r.cmd = CMD_FACE;
            else if (pick < 95)
                r.cmd = CMD_COLUMN;
            else
                r.cmd = 3'($urandom_range(int'(CMD_SPARE5), int'(CMD_SPARE7)));
            if ($urandom_range(0, 9) == 0)
            begin
                r.x = 4'($urandom);
                r.y = 8'($urandom);
                r.z = 4'($urandom);
            end
            else
            begin
                r.x = 4'(ax + $urandom_range(0, 2));
                r.y = 8'(ay + $urandom_range(0, 2));
                r.z = 4'(az + $urandom_range(0, 2));
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
                r.kind = 8'($urandom);
            else if (pick < 75)
                r.kind = see_through;
            else if (pick < 85)
                r.kind = '0;
            else
                r.kind = 8'($urandom_range(128, 255));
            pending_requests.insert(pending_requests.size(), r);
        end
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        foreach (voxels[i])
            voxels[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Extreme offsets: world x at its most negative, world z at its most positive
        write_register(REG_CHUNK_COL, 12'h800);
        write_register(REG_CHUNK_ROW, 12'h7FF);
        write_register(REG_SEE_THROUGH, 12'h001);
        write_register(REG_SPARE, 12'hFFF);
        @(negedge clk);
        queue_request(CMD_GET, 4'd0, 8'd0, 4'd0, 8'h00);
        queue_request(CMD_FACE, 4'd0, 8'd0, 4'd0, 8'h00);
        queue_request(CMD_PUT, 4'd0, 8'd0, 4'd0, 8'hFF);
        queue_request(CMD_GET, 4'd0, 8'd0, 4'd0, 8'h00);
        queue_request(CMD_FACE, 4'd0, 8'd0, 4'd0, 8'h00);
        queue_request(CMD_PUT, 4'd1, 8'd0, 4'd0, 8'h01);
        queue_request(CMD_PUT, 4'd0, 8'd1, 4'd0, 8'h02);
        queue_request(CMD_PUT, 4'd0, 8'd0, 4'd1, 8'h03);
        queue_request(CMD_FACE, 4'd0, 8'd0, 4'd0, 8'h00);
        queue_request(CMD_FACE, 4'd0, 8'd1, 4'd0, 8'h00);
        queue_request(CMD_FACE, 4'd1, 8'd0, 4'd0, 8'h00);
        queue_request(CMD_COLUMN, 4'd0, 8'd77, 4'd0, 8'h00);
        queue_request(CMD_COLUMN, 4'd5, 8'd0, 4'd5, 8'h00);
        queue_request(CMD_PUT, 4'd15, 8'd255, 4'd15, 8'h80);
        queue_request(CMD_FACE, 4'd15, 8'd255, 4'd15, 8'hFF);
        queue_request(CMD_GET, 4'd15, 8'd255, 4'd15, 8'h00);
        queue_request(CMD_REMOVE, 4'd0, 8'd1, 4'd0, 8'hFF);
        queue_request(CMD_GET, 4'd0, 8'd1, 4'd0, 8'h00);
        queue_request(CMD_COLUMN, 4'd0, 8'd255, 4'd0, 8'hFF);
        queue_request(CMD_PUT, 4'd15, 8'd0, 4'd15, 8'h00);
        queue_request(CMD_SPARE5, 4'd15, 8'hAA, 4'd5, 8'h55);
        queue_request(CMD_SPARE6, 4'd10, 8'h55, 4'd10, 8'hAA);
        queue_request(CMD_SPARE7, 4'd0, 8'h00, 4'd0, 8'hFF);
        queue_request(CMD_GET, 4'd0, 8'd0, 4'd0, 8'h00);
        wait_until_drained();

        // Opposite extremes; hold the receiver off while requests keep coming
        write_register(REG_CHUNK_COL, 12'h7FF);
        write_register(REG_CHUNK_ROW, 12'h800);
        write_register(REG_SEE_THROUGH, 12'hFFF);
        @(negedge clk);
        hold_request = 1'b1;
        queue_random_run(25);
        wait_until_drained();

        write_register(REG_CHUNK_COL, 12'hFFF);
        write_register(REG_CHUNK_ROW, 12'h000);
        write_register(REG_SEE_THROUGH, 12'hA80);
        queue_random_run(20);
        wait_until_drained();

        // Reset values but for chunk row 1; fill the bottom of one column, then punch a hole
        write_register(REG_CHUNK_COL, 12'h000);
        write_register(REG_CHUNK_ROW, 12'h001);
        write_register(REG_SEE_THROUGH, 12'h001);
        @(negedge clk);
        for (int y = 0; y < COLUMN_FILL; y++)
            queue_request(CMD_PUT, 4'd7, 8'(y), 4'd9, 8'($urandom_range(1, 255)));
        queue_request(CMD_COLUMN, 4'd7, 8'd0, 4'd9, 8'h00);
        queue_request(CMD_FACE, 4'd7, 8'd8, 4'd9, 8'h00);
        queue_request(CMD_REMOVE, 4'd7, 8'd10, 4'd9, 8'h00);
        queue_request(CMD_COLUMN, 4'd7, 8'd0, 4'd9, 8'h00);
        queue_request(CMD_FACE, 4'd7, 8'd9, 4'd9, 8'h00);
        queue_random_run(10);

        @(negedge clk);
        while (pending_requests.size() != 0 || in_valid)
            @(negedge clk);
        for (int n = 0; n < DRAIN_LIMIT && expected_results.size() != 0; n++)
            @(negedge clk);
        repeat (HEIGHT_DEF + 44) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned, count", 0, expected_results.size());

        $display("Run covered %0d requests and %0d register writes over four settings",
                 requests_sent, reg_writes);
        $display("Checked %0d results, %0d of them exposed faces; %0d mismatches",
                 results_checked, faces_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d requests queued and %0d results outstanding",
                 pending_requests.size(), expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[voxel_store_face_culler.f]
hw/rtl/vsfc_pkg.sv
hw/rtl/voxel_store_face_culler.sv
dv/tb.sv
